>>> design/alws_pkg.sv
// ----------------------------------------------------------------------------
// alws_pkg: shared types and constants of the waypoint sampler
// Sequencer states, length width, spacing width and its reset value.
// ----------------------------------------------------------------------------
package alws_pkg;

    localparam int LEN_BITS     = 40;
    localparam int SPACING_BITS = 16;

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd768;
    localparam logic [LEN_BITS-1:0]     LEN_MAX       = {LEN_BITS{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_START,
        S_ROOT,
        S_ACCUM,
        S_CMP,
        S_LOAD,
        S_OUT
    } t_state;

endpackage

>>> design/arc_length_waypoint_sampler.sv
// ----------------------------------------------------------------------------
// arc_length_waypoint_sampler: arc-length resampling of a point path
// Accumulates Euclidean segment lengths and picks a point index, at most one per
// segment, as the length passes the next multiple of the spacing; also path start and end.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | beat contents
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_pos_x, i_pos_y, i_path_end
//  out     | output    | o_out_valid / i_out_ready | o_point_index, o_end_of_path,
//          |           |                           | o_last_of_run
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_sample_spacing
//
//  The first point of a path produces no beat. Every later point steps through
//  the difference, square, sum, start, bit-serial square root, accumulate and
//  compare states, then a load and an output state per result beat;
//  o_in_ready stays low until the last beat is taken.
//  A stalled output holds its beat and the sequencer waits in place.
//  Spacing beats are taken only while the sequencer is idle.
//  Synchronous active-low reset restores spacing 768 and an empty path.
//
module arc_length_waypoint_sampler #(
    parameter int COORD_BITS = 24,
    parameter int INDEX_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // point channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic                  i_path_end,
    // sample channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [INDEX_BITS-1:0] o_point_index,
    output logic                  o_end_of_path,
    output logic                  o_last_of_run,
    // spacing register write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [alws_pkg::SPACING_BITS-1:0] i_cfg_sample_spacing
);

    import alws_pkg::*;

    localparam int ROOT_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int SEEN_BITS = INDEX_BITS + 1;

    // pending result slots, in emission order
    localparam int P_ZERO = 0;
    localparam int P_HIT  = 1;
    localparam int P_END  = 2;

    t_state r_state, n_state;

    // path state
    logic [COORD_BITS-1:0]   r_prev_x, r_prev_y;
    logic [SEEN_BITS-1:0]    r_seen;
    logic [LEN_BITS-1:0]     r_len;
    logic [LEN_BITS-1:0]     r_thr;
    logic [SPACING_BITS-1:0] r_spacing;

    // item in flight
    logic [COORD_BITS-1:0]   r_x, r_y;
    logic                    r_end;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    logic [PROD_BITS-1:0]    r_prod, r_acc;
    logic [SQ_BITS-1:0]      r_sq;
    logic [2:0]              r_pend;
    logic [INDEX_BITS-1:0]   r_hit_idx, r_end_idx;

    // output register
    logic [INDEX_BITS-1:0]   r_out_idx;
    logic                    r_out_end;
    logic                    r_out_last;

    // combinational helpers
    logic signed [COORD_BITS:0] n_diff_x, n_diff_y;
    logic [COORD_BITS-1:0]      n_mul_op;
    logic [LEN_BITS:0]          n_len_sum, n_thr_sum;
    logic                       n_hit;
    logic [2:0]                 n_pend_cmp;
    logic [2:0]                 n_pend_left;
    logic [SEEN_BITS-1:0]       n_seen_dec;

    // sqrt unit
    logic                 w_sq_start;
    logic                 w_sq_done;
    logic [ROOT_BITS-1:0] w_root;

    // clamp a point count to the index range
    function automatic logic [INDEX_BITS-1:0] sat_index(input logic [SEEN_BITS-1:0] v);
        sat_index = v[SEEN_BITS-1] ? {INDEX_BITS{1'b1}} : v[INDEX_BITS-1:0];
    endfunction

    alws_isqrt #(
        .ROOT_BITS (ROOT_BITS)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand ({1'b0, r_sq}),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    // datapath arithmetic
    always_comb begin
        n_diff_x   = $signed({r_x[COORD_BITS-1], r_x})
                   - $signed({r_prev_x[COORD_BITS-1], r_prev_x});
        n_diff_y   = $signed({r_y[COORD_BITS-1], r_y})
                   - $signed({r_prev_y[COORD_BITS-1], r_prev_y});
        // one multiplier, squared dx first, then dy
        n_mul_op   = (r_state == S_SQX) ? r_dx : r_dy;
        n_len_sum  = {1'b0, r_len} + (LEN_BITS + 1)'(w_root);
        n_thr_sum  = {1'b0, r_thr} + (LEN_BITS + 1)'(r_spacing);
        n_hit      = (r_len > r_thr);
        n_pend_cmp = {r_end, n_hit, (r_seen == SEEN_BITS'(1))};
        n_seen_dec = r_seen - SEEN_BITS'(1);
        // drop the lowest pending slot
        n_pend_left = r_pend & (r_pend - 3'd1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (r_seen != '0)) n_state = S_DIFF;
            end
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SUM;
            S_SUM:   n_state = S_START;
            S_START: n_state = S_ROOT;
            S_ROOT: begin
                if (w_sq_done) n_state = S_ACCUM;
            end
            S_ACCUM: n_state = S_CMP;
            S_CMP: begin
                n_state = (n_pend_cmp != 3'b000) ? S_LOAD : S_IDLE;
            end
            S_LOAD:  n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) n_state = (r_pend != 3'b000) ? S_LOAD : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state-driven outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_cfg_ready = (r_state == S_IDLE);
        w_sq_start  = (r_state == S_START);
    end

    assign o_point_index = r_out_idx;
    assign o_end_of_path = r_out_end;
    assign o_last_of_run = r_out_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_seen    <= '0;
            r_len     <= '0;
            r_thr     <= LEN_BITS'(SPACING_RESET);
            r_spacing <= SPACING_RESET;
            r_pend    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    // first point of a path: remember it, or drop a lone point
                    if (i_in_valid && (r_seen == '0)) begin
                        if (i_path_end) begin
                            r_prev_x <= '0;
                            r_prev_y <= '0;
                            r_len    <= '0;
                            r_thr    <= LEN_BITS'(r_spacing);
                        end else begin
                            r_prev_x <= i_pos_x;
                            r_prev_y <= i_pos_y;
                            r_seen   <= SEEN_BITS'(1);
                        end
                    end
                end
                S_ACCUM: begin
                    r_len <= n_len_sum[LEN_BITS] ? LEN_MAX : n_len_sum[LEN_BITS-1:0];
                end
                S_CMP: begin
                    r_pend <= n_pend_cmp;
                    if (r_end) begin
                        // restart the path
                        r_prev_x <= '0;
                        r_prev_y <= '0;
                        r_seen   <= '0;
                        r_len    <= '0;
                        r_thr    <= LEN_BITS'(r_spacing);
                    end else begin
                        r_prev_x <= r_x;
                        r_prev_y <= r_y;
                        if (r_seen != {SEEN_BITS{1'b1}}) r_seen <= r_seen + SEEN_BITS'(1);
                        if (n_hit) begin
                            r_thr <= n_thr_sum[LEN_BITS] ? LEN_MAX
                                                         : n_thr_sum[LEN_BITS-1:0];
                        end
                    end
                end
                S_LOAD: begin
                    r_pend <= n_pend_left;
                end
                default: begin
                end
            endcase
            // spacing write, only while idle
            if (i_cfg_valid && o_cfg_ready) begin
                r_spacing <= i_cfg_sample_spacing;
                if (r_seen == '0) r_thr <= LEN_BITS'(i_cfg_sample_spacing);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_pos_x;
                r_y   <= i_pos_y;
                r_end <= i_path_end;
            end
            S_DIFF: begin
                r_dx <= n_diff_x[COORD_BITS] ? COORD_BITS'(-n_diff_x)
                                             : n_diff_x[COORD_BITS-1:0];
                r_dy <= n_diff_y[COORD_BITS] ? COORD_BITS'(-n_diff_y)
                                             : n_diff_y[COORD_BITS-1:0];
            end
            S_SQX: begin
                r_prod <= n_mul_op * n_mul_op;
            end
            S_SQY: begin
                r_acc  <= r_prod;
                r_prod <= n_mul_op * n_mul_op;
            end
            S_SUM: begin
                r_sq <= {1'b0, r_acc} + {1'b0, r_prod};
            end
            S_CMP: begin
                r_hit_idx <= sat_index(n_seen_dec);
                r_end_idx <= sat_index(r_seen);
            end
            S_LOAD: begin
                // start point first, then the crossing, then the path end
                if (r_pend[P_ZERO]) begin
                    r_out_idx <= '0;
                    r_out_end <= 1'b0;
                end else if (r_pend[P_HIT]) begin
                    r_out_idx <= r_hit_idx;
                    r_out_end <= 1'b0;
                end else begin
                    r_out_idx <= r_end_idx;
                    r_out_end <= r_pend[P_END];
                end
                r_out_last <= (n_pend_left == 3'b000);
            end
            default: begin
            end
        endcase
    end

    // the two channels never overlap: a beat waits while input is held off
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result beat is offered");

    // the root finishes only while the sequencer waits for it
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

    // the last beat of a run leaves nothing pending
    a_last_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run) |-> (r_pend == 3'b000))
        else $error("last beat flagged with results still pending");

    // an empty path has no accumulated length
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen == '0) |-> (r_len == '0))
        else $error("length kept without a path in progress");

    // a run of beats ends with the last flag before input is taken again
    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_run) |=> !o_in_ready)
        else $error("run left open when input reopened");

endmodule

>>> design/alws_isqrt.sv
// ----------------------------------------------------------------------------
// alws_isqrt: bit-serial integer square root
// Restoring digit-by-digit root, one result bit per cycle, floor result.
// ----------------------------------------------------------------------------
module alws_isqrt #(
    parameter int ROOT_BITS = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*ROOT_BITS-1:0] i_radicand,
    output logic                   o_done,
    output logic [ROOT_BITS-1:0]   o_root
);

    localparam int RAD_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 3;
    localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [ROOT_BITS-1:0] r_root;

    logic [REM_BITS-1:0]  n_rem_sh;
    logic [REM_BITS-1:0]  n_trial;
    logic                 n_fit;

    // bring down the next two radicand bits and try a one digit
    always_comb begin
        n_rem_sh = {r_rem[REM_BITS-3:0], r_rad[RAD_BITS-1 -: 2]};
        n_trial  = {1'b0, r_root, 2'b01};
        n_fit    = (n_rem_sh >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(ROOT_BITS);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
                r_rem  <= n_fit ? (n_rem_sh - n_trial) : n_rem_sh;
                r_root <= {r_root[ROOT_BITS-2:0], n_fit};
                r_cnt  <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> sim/tb_arc_length_waypoint_sampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arc_length_waypoint_sampler: self-checking bench of the waypoint sampler
// Streams path points through the point channel and predicts the sample beats
// from a cycle-free path tracker kept beside the block. Every returned sample
// is compared field by field with the oldest prediction. The spacing register
// is rewritten between phases, including in the middle of an open path.
// ----------------------------------------------------------------------------
module tb_arc_length_waypoint_sampler;

    import alws_pkg::*;

    localparam int COORD_W = 24;
    localparam int IDX_W   = 16;

    localparam int COORD_MIN = -8388608;
    localparam int COORD_MAX = 8388607;

    // 17-bit point counter and 16-bit index saturation limits
    localparam logic [IDX_W:0]   COUNT_MAX = {(IDX_W+1){1'b1}};
    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

    // a point without a sample still keeps the sequencer busy through its arithmetic
    localparam int          SETTLE_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned IDLE_PERCENT  = 16;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               fin;
    } t_point;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             fin;
        logic             last;
    } t_sample;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [COORD_W-1:0]   i_pos_x = '0;
    logic [COORD_W-1:0]   i_pos_y = '0;
    logic                 i_path_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [IDX_W-1:0]     o_point_index;
    logic                 o_end_of_path;
    logic                 o_last_of_run;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [15:0]          i_cfg_sample_spacing = '0;

    // bench control
    t_point      pending_pts[$];
    t_sample     samples_due[$];
    int unsigned faults = 0;
    int unsigned cycles = 0;
    logic        quiet = 1'b0;      // no idling on either side while high
    logic        hold_kick = 1'b0;  // one-cycle request for a long receiver hold-off
    int unsigned hold_left = 0;

    // path tracker state
    logic [COORD_W-1:0]      trk_prev_x;
    logic [COORD_W-1:0]      trk_prev_y;
    logic [IDX_W:0]          trk_count;
    logic [LEN_BITS-1:0]     trk_length;
    logic [LEN_BITS-1:0]     trk_mark;
    logic [SPACING_BITS-1:0] trk_spacing;

    arc_length_waypoint_sampler #(
        .COORD_BITS (COORD_W),
        .INDEX_BITS (IDX_W)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_path_end           (i_path_end),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_point_index        (o_point_index),
        .o_end_of_path        (o_end_of_path),
        .o_last_of_run        (o_last_of_run),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_sample_spacing (i_cfg_sample_spacing)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Path tracker
    // ------------------------------------------------------------------

    // floor of the square root, bit by bit from the top
    function automatic logic [25:0] floor_root(input logic [49:0] v);
        logic [25:0] r;
        logic [25:0] c;
        logic [51:0] c2;
        r = '0;
        for (int k = 25; k >= 0; k--) begin
            c  = r | (26'd1 << k);
            c2 = c * c;
            if (c2 <= {2'b00, v}) r = c;
        end
        return r;
    endfunction

    function automatic logic [LEN_BITS-1:0] clamp_len(input logic [LEN_BITS:0] v);
        return (v > {1'b0, LEN_MAX}) ? LEN_MAX : v[LEN_BITS-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] clamp_index(input logic [IDX_W:0] v);
        return (v > {1'b0, INDEX_MAX}) ? INDEX_MAX : v[IDX_W-1:0];
    endfunction

    task automatic restart_track();
        trk_prev_x = '0;
        trk_prev_y = '0;
        trk_count  = '0;
        trk_length = '0;
        trk_mark   = {{(LEN_BITS-SPACING_BITS){1'b0}}, trk_spacing};
    endtask

    // advance the tracker by one accepted point and queue the samples it causes
    task automatic advance_path(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic fin);
        t_sample             batch[$];
        logic signed [COORD_W:0] ddx;
        logic signed [COORD_W:0] ddy;
        logic [COORD_W:0]    ax;
        logic [COORD_W:0]    ay;
        logic [49:0]         sq;
        logic [25:0]         seg;
        if (trk_count == 0) begin
            // first point of a path: remember it, or drop a one-point path
            if (fin) begin
                restart_track();
            end else begin
                trk_prev_x = x;
                trk_prev_y = y;
                trk_count  = (IDX_W+1)'(1);
            end
            return;
        end
        ddx = $signed(x) - $signed(trk_prev_x);
        ddy = $signed(y) - $signed(trk_prev_y);
        ax  = (ddx < 0) ? -ddx : ddx;
        ay  = (ddy < 0) ? -ddy : ddy;
        sq  = ax * ax + ay * ay;
        seg = floor_root(sq);
        trk_length = clamp_len({1'b0, trk_length} + seg);

        if (trk_count == 1) batch.insert(batch.size(), t_sample'{'0, 1'b0, 1'b0});
        // strictly greater; at most one sample per segment
        if (trk_length > trk_mark) begin
            batch.insert(batch.size(),
                         t_sample'{clamp_index(trk_count - 1'b1), 1'b0, 1'b0});
            trk_mark = clamp_len({1'b0, trk_mark} + trk_spacing);
        end
        if (fin) begin
            batch.insert(batch.size(), t_sample'{clamp_index(trk_count), 1'b1, 1'b0});
            restart_track();
        end else begin
            trk_prev_x = x;
            trk_prev_y = y;
            if (trk_count < COUNT_MAX) trk_count = trk_count + 1'b1;
        end
        if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) samples_due.insert(samples_due.size(), batch[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_point(input int x, input int y, input bit fin);
        pending_pts.insert(pending_pts.size(),
                           t_point'{x[COORD_W-1:0], y[COORD_W-1:0], fin});
    endfunction

    // mostly whole paths with random steps, some scaled to the spacing, some noise
    // points and some paths cut off before their end flag
    task automatic add_random_phase(input int unsigned n, input int unsigned spacing);
        int unsigned made;
        int unsigned len;
        int unsigned step;
        int          off;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        bit          cut;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 99) < 12) begin
                add_point(int'($urandom), int'($urandom), 1'($urandom_range(0, 1)));
                made++;
            end else begin
                len = $urandom_range(2, 9);
                cut = ($urandom_range(0, 99) < 10);
                px  = COORD_W'($urandom);
                py  = COORD_W'($urandom);
                case ($urandom_range(0, 3))
                    0:       step = spacing / 4;
                    1:       step = spacing * 2;
                    2:       step = 1 << 23;
                    default: step = 0;
                endcase
                for (int k = 0; k < len; k++) begin
                    if (k > 0) begin
                        off = int'($urandom_range(0, 2 * step)) - int'(step);
                        px  = px + COORD_W'(off);
                        off = int'($urandom_range(0, 2 * step)) - int'(step);
                        py  = py + COORD_W'(off);
                    end
                    add_point(int'(px), int'(py), (k == len - 1) && !cut);
                    made++;
                end
            end
        end
    endtask

    // wait until every point is taken and every sample returned, then let the
    // sequencer finish any point that produces no sample
    task automatic drain();
        while (pending_pts.size() != 0 || i_in_valid || samples_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the spacing register; only called while the block is idle
    task automatic write_spacing(input logic [SPACING_BITS-1:0] value);
        i_cfg_valid          <= 1'b1;
        i_cfg_sample_spacing <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        trk_spacing = value;
        // an open path keeps its threshold; only later increments change
        if (trk_count == 0) trk_mark = {{(LEN_BITS-SPACING_BITS){1'b0}}, value};
    endtask

    task automatic log_fault(input string what);
        faults++;
        if (faults <= 10) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Point driver: present the next queued point, hold it until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_points
        t_point nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) advance_path(i_pos_x, i_pos_y, i_path_end);
            if (!i_in_valid || o_in_ready) begin
                // slot is free: load a point unless this cycle is a gap
                if (pending_pts.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    nxt = pending_pts.pop_front();
                    i_pos_x    <= nxt.x;
                    i_pos_y    <= nxt.y;
                    i_path_end <= nxt.fin;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted here
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Sample monitor: drive ready, check each beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_samples
        t_sample want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= (hold_left == 0) &&
                           (quiet || $urandom_range(0, 99) >= IDLE_PERCENT);
            if (o_out_valid && i_out_ready) begin
                if (samples_due.size() == 0) begin
                    log_fault($sformatf("unexpected sample index=%0d end=%0b last=%0b",
                                        o_point_index, o_end_of_path, o_last_of_run));
                end else begin
                    want = samples_due.pop_front();
                    if (o_point_index !== want.index || o_end_of_path !== want.fin ||
                        o_last_of_run !== want.last) begin
                        log_fault($sformatf(
                            "expected index=%0d end=%0b last=%0b, got index=%0d end=%0b last=%0b",
                            want.index, want.fin, want.last,
                            o_point_index, o_end_of_path, o_last_of_run));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : run_sequence
        int unsigned spacing;
        trk_spacing = SPACING_RESET;
        restart_track();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset spacing of 3 m
        add_point(100, 200, 1'b1);                  // one-point path: no sample
        add_point(0, 0, 1'b0);                      // first segment passes 768:
        add_point(1000, 0, 1'b0);                   //   index 0 twice
        add_point(1000, 0, 1'b1);                   // zero-length end segment
        add_point(COORD_MIN, COORD_MIN, 1'b0);      // opposite corners
        add_point(COORD_MAX, COORD_MAX, 1'b0);
        add_point(COORD_MAX, COORD_MIN, 1'b0);
        add_point(COORD_MIN, COORD_MAX, 1'b1);      // two samples from one point
        add_point(5, -5, 1'b0);                     // short steps, leave path open
        add_point(6, -5, 1'b0);
        add_point(6, -4, 1'b0);
        add_point(300, 400, 1'b0);
        add_point(700, 900, 1'b0);
        drain();

        // largest spacing written mid-path: current threshold stays
        write_spacing(16'hFFFF);
        add_point(1500, 900, 1'b0);
        add_point(-1500, 900, 1'b1);
        drain();

        // zero spacing: any positive length keeps emitting
        write_spacing('0);
        add_point(7, 7, 1'b0);
        add_point(7, 7, 1'b0);
        add_point(8, 7, 1'b0);
        add_point(8, 7, 1'b1);
        drain();

        // spacing of one, then random phases
        write_spacing(16'd1);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0:       spacing = 1;
                1:       spacing = 65535;
                2:       spacing = 768;
                3:       spacing = $urandom_range(100, 2000);
                default: spacing = $urandom_range(1, 65535);
            endcase
            if (ph != 0) write_spacing(spacing[SPACING_BITS-1:0]);
            // one phase without idling, one with a long receiver stall
            quiet     <= (ph == 2);
            hold_kick <= (ph == 3);
            add_random_phase(44, spacing);
            @(posedge i_clk);
            hold_kick <= 1'b0;
            drain();
        end
        quiet <= 1'b0;

        if (faults == 0 && samples_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/alws_pkg.sv
design/alws_isqrt.sv
design/arc_length_waypoint_sampler.sv
sim/tb_arc_length_waypoint_sampler.sv
